[src/plt_pkg.sv]
package plt_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int ITEM_W         = 32;
    localparam int OPCODE_W       = 2;
    localparam int POS_W          = 5;
    localparam int STATUS_W       = 3;
    localparam int FIDX_W         = 4;
    localparam int ECNT_W         = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_match;
        logic scan_shift;
    } cell_ctrl_t;

endpackage

[src/positional_list_table.sv]
// Insert and delete: the result reaches the output register in the cycle after acceptance.
// Find: compare in all cells at once, then the match flags shift toward cell 0 one
// cell per cycle; the result is registered when the flag of the first match reaches
// cell 0, or once the flag of cell count - 1 has been checked there if none matches.
// One operation is in flight at a time; the next is taken once the result register is free.
// Reset (aresetn low, synchronous) empties the list and drops any pending result.
module positional_list_table
    import plt_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [33:2] item_value, [38:34] position, [39] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [6:3] found_index, [11:7] entry_count, [15:12] zero
    output logic [15:0] m_tdata
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    logic [OPCODE_W-1:0] s_opcode;
    logic [ITEM_W-1:0]   s_item_value;
    logic [POS_W-1:0]    s_position;

    assign s_opcode     = s_tdata[1:0];
    assign s_item_value = s_tdata[33:2];
    assign s_position   = s_tdata[38:34];

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       scan_reg, scan_next;
    logic [ITEM_W-1:0]   value_reg, value_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FIDX_W-1:0]   fidx_reg, fidx_next;
    logic [ECNT_W-1:0]   ecnt_reg, ecnt_next;

    logic                accept;
    logic                insert_ok;
    logic                delete_ok;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic [PW-1:0]       tgt;
    logic [PW-1:0]       scan_ext;
    cell_ctrl_t          ctrl;
    logic [ITEM_W-1:0]   cell_value;
    logic [ITEM_W-1:0]   entries [LIST_DEPTH];
    logic [LIST_DEPTH:0] match_bits;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign pos_ext  = PW'(s_position);
    assign cnt_ext  = PW'(count_reg);
    assign tgt      = pos_ext - PW'(1);
    assign scan_ext = PW'(scan_reg);

    assign insert_ok = accept && (s_opcode == OP_INSERT) && (count_reg < DEPTH_C)
                       && (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
    assign delete_ok = accept && (s_opcode == OP_DELETE) && (count_reg != '0)
                       && (pos_ext != '0) && (pos_ext <= cnt_ext);

    assign cell_value      = (state_reg == S_SCAN) ? value_reg : s_item_value;
    assign ctrl.shift_up   = insert_ok;
    assign ctrl.shift_down = delete_ok;
    assign ctrl.load_match = accept && (s_opcode == OP_FIND);
    assign ctrl.scan_shift = (state_reg == S_SCAN);

    assign match_bits[LIST_DEPTH] = 1'b0;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [ITEM_W-1:0] left_entry;
        logic [ITEM_W-1:0] right_entry;
        if (i == 0) begin : g_first
            assign left_entry = cell_value;
        end else begin : g_mid
            assign left_entry = entries[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_entry = cell_value;
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end
        plt_cell #(
            .INDEX (i),
            .CNT_W (PW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .tgt         (tgt),
            .cnt         (cnt_ext),
            .value       (cell_value),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .right_match (match_bits[i+1]),
            .entry       (entries[i]),
            .match       (match_bits[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        fidx_next    = fidx_reg;
        ecnt_next    = ecnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    fidx_next = '0;
                    case (s_opcode)
                        OP_INSERT: begin
                            m_valid_next = 1'b1;
                            if (count_reg >= DEPTH_C) begin
                                status_next = ST_FULL;
                            end else if (!insert_ok) begin
                                status_next = ST_BADPOS;
                            end else begin
                                status_next = ST_OK;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (!delete_ok) begin
                                status_next = ST_BADPOS;
                            end else begin
                                status_next = ST_OK;
                                count_next  = count_reg - CW'(1);
                            end
                        end
                        OP_FIND: begin
                            state_next = S_SCAN;
                            scan_next  = '0;
                            value_next = s_item_value;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            status_next  = ST_BADPOS;
                        end
                    endcase
                    ecnt_next = POS_W'(PW'(count_next));
                end
            end
            S_SCAN: begin
                if (match_bits[0]) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = ST_OK;
                    fidx_next    = scan_ext[FIDX_W-1:0];
                    ecnt_next    = cnt_ext[ECNT_W-1:0];
                end else if (scan_ext + PW'(1) >= cnt_ext) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = ST_NOTFOUND;
                    fidx_next    = '0;
                    ecnt_next    = cnt_ext[ECNT_W-1:0];
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        scan_reg   <= scan_next;
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        ecnt_reg   <= ecnt_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, ecnt_reg, fidx_reg, status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_scan_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !s_tready && !m_valid_reg)
        else $error("transaction accepted or result pending during scan");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        insert_ok |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        delete_ok |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not shrink the list");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_FULL) |-> (count_reg == DEPTH_C))
        else $error("full status on a list that is not full");

endmodule

[src/plt_cell.sv]
module plt_cell
    import plt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  tgt,
    input  logic [CNT_W-1:0]  cnt,
    input  logic [ITEM_W-1:0] value,
    input  logic [ITEM_W-1:0] left_entry,
    input  logic [ITEM_W-1:0] right_entry,
    input  logic              right_match,
    output logic [ITEM_W-1:0] entry,
    output logic              match
);

    localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

    logic [ITEM_W-1:0] entry_reg, entry_next;
    logic              match_reg, match_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.shift_up) begin
            if (IDX == tgt) begin
                entry_next = value;
            end else if (IDX > tgt && IDX <= cnt) begin
                entry_next = left_entry;
            end
        end else if (ctrl.shift_down) begin
            if (IDX >= tgt && IDX_P1 < cnt) begin
                entry_next = right_entry;
            end
        end
    end

    always_comb begin
        match_next = match_reg;
        if (ctrl.load_match) begin
            match_next = (IDX < cnt) && (entry_reg == value);
        end else if (ctrl.scan_shift) begin
            match_next = right_match;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

[bench/tb_positional_list_table.sv]
module tb_positional_list_table;
    import plt_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_RANDOM  = 420;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [ITEM_W-1:0]   item_value;
        logic [POS_W-1:0]    position;
        bit                  pause_before;
    } list_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FIDX_W-1:0]   found_index;
        logic [ECNT_W-1:0]   entry_count;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];
    list_op_t     offered_op;
    list_result_t oldest_result;

    logic [ITEM_W-1:0] shadow_entries[LIST_DEPTH_DEF];
    int shadow_count = 0;
    int gen_count = 0;
    int accepted = 0;
    int error_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;

    logic [ITEM_W-1:0] value_pool[8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                         32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005,
                                         32'h0000_3039, 32'hFFFF_FFB3};

    positional_list_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic list_result_t apply_list_op(list_op_t t);
        list_result_t r;
        int p;
        int j;
        p = int'(t.position);
        r.status = ST_BADPOS;
        r.found_index = '0;
        case (t.opcode)
            OP_INSERT: begin
                if (shadow_count >= LIST_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else if (p >= 1 && p <= shadow_count + 1) begin
                    for (j = shadow_count; j > p - 1; j--)
                        shadow_entries[j] = shadow_entries[j - 1];
                    shadow_entries[p - 1] = t.item_value;
                    shadow_count++;
                    r.status = ST_OK;
                end
            end
            OP_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= 1 && p <= shadow_count) begin
                    for (j = p - 1; j + 1 < shadow_count; j++)
                        shadow_entries[j] = shadow_entries[j + 1];
                    shadow_count--;
                    r.status = ST_OK;
                end
            end
            OP_FIND: begin
                r.status = ST_NOTFOUND;
                for (j = shadow_count - 1; j >= 0; j--) begin
                    if (shadow_entries[j] == t.item_value) begin
                        r.status = ST_OK;
                        r.found_index = FIDX_W'(j);
                    end
                end
            end
            default: r.status = ST_BADPOS;
        endcase
        r.entry_count = ECNT_W'(shadow_count);
        return r;
    endfunction

    // Track the list length while queuing so that positions can be aimed at valid slots.
    task automatic queue_op(logic [OPCODE_W-1:0] op, logic [ITEM_W-1:0] value,
                            int pos, bit pause);
        list_op_t t;
        t.opcode = op;
        t.item_value = value;
        t.position = POS_W'(pos);
        t.pause_before = pause;
        pending_ops.push_back(t);
        if (op == OP_INSERT && gen_count < LIST_DEPTH_DEF && pos >= 1 && pos <= gen_count + 1)
            gen_count++;
        else if (op == OP_DELETE && gen_count > 0 && pos >= 1 && pos <= gen_count)
            gen_count--;
    endtask

    function automatic logic [ITEM_W-1:0] pick_value();
        if ($urandom_range(99) < 55)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    function automatic int tx_idle_pct(int n);
        if (n < 160) return 17;
        if (n < 320) return 58;
        return 0;
    endfunction

    function automatic int rx_idle_pct(int n);
        if (n < 160) return 58;
        if (n < 320) return 17;
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_list_op(offered_op));
                accepted <= accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0
                    && !(pending_ops[0].pause_before && expected_results.size() != 0)
                    && $urandom_range(99) >= tx_idle_pct(accepted)) begin
                    offered_op = pending_ops.pop_front();
                    s_tdata  <= {1'b0, offered_op.position, offered_op.item_value,
                                 offered_op.opcode};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!stall_done && accepted >= 60) begin
            // hold off long enough for the input side to back up
            stall_left <= 80;
            stall_done <= 1'b1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct(accepted));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                oldest_result = expected_results.pop_front();
                compare_field("status", oldest_result.status, m_tdata[2:0]);
                compare_field("found_index", oldest_result.found_index, m_tdata[6:3]);
                compare_field("entry_count", oldest_result.entry_count, m_tdata[11:7]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        bit filling;
        int k;
        int pick;
        int pos;
        logic [OPCODE_W-1:0] op;

        // empty list corner cases
        queue_op(OP_FIND,   32'h0000_0000, 1, 1'b0);
        queue_op(OP_DELETE, 32'hFFFF_FFFF, 1, 1'b0);
        queue_op(OP_INSERT, 32'h1234_5678, 0, 1'b0);
        queue_op(OP_INSERT, 32'h1234_5678, 2, 1'b0);
        queue_op(OP_UNUSED, 32'hFFFF_FFFF, 31, 1'b0);
        // fill to capacity: front, back and middle, with repeated values
        for (k = 0; k < LIST_DEPTH_DEF; k++) begin
            case (k % 3)
                0:       pos = 1;
                1:       pos = gen_count + 1;
                default: pos = gen_count / 2 + 1;
            endcase
            queue_op(OP_INSERT, value_pool[k % 8], pos, 1'b0);
        end
        queue_op(OP_INSERT, 32'hDEAD_BEEF, 31, 1'b0);
        queue_op(OP_FIND,   32'h8000_0000, 31, 1'b0);
        queue_op(OP_DELETE, 32'h0000_0000, 17, 1'b0);
        queue_op(OP_DELETE, 32'h0000_0000, 16, 1'b0);
        queue_op(OP_DELETE, 32'h0000_0000, 0, 1'b0);
        queue_op(OP_FIND,   32'h1357_9BDF, 0, 1'b0);
        queue_op(OP_INSERT, 32'h7FFF_FFFF, gen_count + 2, 1'b0);
        queue_op(OP_DELETE, 32'hA5A5_A5A5, 1, 1'b0);

        filling = 1'b1;
        for (k = 0; k < NUM_RANDOM; k++) begin
            if ($urandom_range(29) == 0
                || (filling && gen_count == LIST_DEPTH_DEF && $urandom_range(3) == 0)
                || (!filling && gen_count == 0 && $urandom_range(3) == 0))
                filling = !filling;
            pick = $urandom_range(99);
            if (pick < 2)
                op = OP_UNUSED;
            else if (pick < 16)
                op = OP_FIND;
            else if (pick < 81)
                op = filling ? OP_INSERT : OP_DELETE;
            else
                op = filling ? OP_DELETE : OP_INSERT;
            if ($urandom_range(99) < 15 || op == OP_FIND || op == OP_UNUSED)
                pos = $urandom_range(31);
            else if (op == OP_INSERT)
                pos = $urandom_range(gen_count + 1, 1);
            else
                pos = $urandom_range(gen_count > 0 ? gen_count : 1, 1);
            queue_op(op, pick_value(), pos, (k == 150 || k == 380));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
